// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, disabled while reset is asserted (active low).
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, constants and helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int unsigned SIZE_BITS_DEF = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // bytes dropped after each chunk payload (the CR LF that closes it)
  localparam logic [1:0] SKIP_BYTES = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload;
    logic       kind;
  } cbd_result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/cbd_parser.sv =====
// ----------------------------------------------------------------------------
// cbd_parser
// Parser state and one-byte step: size line, payload pass-through, skip, done.
// ----------------------------------------------------------------------------
module cbd_parser #(
  parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  logic [7:0]          data_byte_i,
  input  logic                new_body_i,
  output cbd_pkg::cbd_result_t result_o
);

  localparam logic [1:0] PH_SIZE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [SIZE_BITS-1:0] REM_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

  logic [1:0]           phase_q, phase_d;
  logic [SIZE_BITS-1:0] rem_q, rem_d;
  logic                 stopped_q, stopped_d;
  logic                 cr_pend_q, cr_pend_d;
  logic [1:0]           skip_q, skip_d;

  // state as seen by this byte, after an optional restart
  logic [1:0]           ph_c;
  logic [SIZE_BITS-1:0] rem_c;
  logic                 stopped_c;
  logic                 cr_pend_c;
  logic [1:0]           skip_c;

  logic [4:0]           hex;
  logic [SIZE_BITS-1:0] rem_shift;
  logic [SIZE_BITS-1:0] rem_dec;
  logic [1:0]           skip_dec;

  always_comb begin
    if (new_body_i) begin
      ph_c      = PH_SIZE;
      rem_c     = '0;
      stopped_c = 1'b0;
      cr_pend_c = 1'b0;
      skip_c    = 2'd0;
    end else begin
      ph_c      = phase_q;
      rem_c     = rem_q;
      stopped_c = stopped_q;
      cr_pend_c = cr_pend_q;
      skip_c    = skip_q;
    end
  end

  assign hex       = cbd_pkg::hex_decode(data_byte_i);
  assign rem_shift = {rem_c[SIZE_BITS-5:0], hex[3:0]};
  assign rem_dec   = rem_c - REM_ONE;
  assign skip_dec  = (skip_c != 2'd0) ? (skip_c - 2'd1) : skip_c;

  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    stopped_d = stopped_q;
    cr_pend_d = cr_pend_q;
    skip_d    = skip_q;
    result_o  = '0;
    if (step_en_i) begin
      phase_d   = ph_c;
      rem_d     = rem_c;
      stopped_d = stopped_c;
      cr_pend_d = cr_pend_c;
      skip_d    = skip_c;
      unique case (ph_c)
        PH_SIZE: begin
          if (cr_pend_c && data_byte_i == cbd_pkg::CHAR_LF) begin
            cr_pend_d = 1'b0;
            stopped_d = 1'b0;
            if (rem_c == '0) begin
              phase_d          = PH_DONE;
              result_o.valid   = 1'b1;
              result_o.payload = 8'h00;
              result_o.kind    = cbd_pkg::KIND_END;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            cr_pend_d = (data_byte_i == cbd_pkg::CHAR_CR);
            if (!stopped_c) begin
              if (hex[4]) begin
                rem_d = rem_shift;
              end else begin
                stopped_d = 1'b1;
              end
            end
          end
        end
        PH_DATA: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_SKIP;
            skip_d  = cbd_pkg::SKIP_BYTES;
          end
          result_o.valid   = 1'b1;
          result_o.payload = data_byte_i;
          result_o.kind    = cbd_pkg::KIND_PAYLOAD;
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 2'd0) begin
            phase_d   = PH_SIZE;
            rem_d     = '0;
            stopped_d = 1'b0;
            cr_pend_d = 1'b0;
          end
        end
        default: begin
          // done: swallow bytes until the next body
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIZE;
      rem_q     <= '0;
      stopped_q <= 1'b0;
      cr_pend_q <= 1'b0;
      skip_q    <= 2'd0;
    end else begin
      phase_q   <= phase_d;
      rem_q     <= rem_d;
      stopped_q <= stopped_d;
      cr_pend_q <= cr_pend_d;
      skip_q    <= skip_d;
    end
  end

endmodule

// ===== rtl/chunked_body_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// chunked_body_decoder_unit
// HTTP chunked body decoder: one raw byte in, at most one payload byte or
// end marker out.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)   tuser
//  s_axis   in   data_byte[7:0]       new_body
//  m_axis   out  payload_byte[7:0]    kind (0 payload, 1 end of body)
//
//  One item per cycle sustained while m_axis_tready holds; a result passes
//  through the input register, then the parser step into the output
//  register, before it appears on m_axis.
//  Items that yield nothing (size line, skip, after end) leave no gap.
//  The parser advances only when the output register is free or being taken,
//  so m_axis_tready stalls ripple back to s_axis_tready within the cycle.
//  rst_ni clears all control state; the parser restarts on a size line.
// ----------------------------------------------------------------------------
module chunked_body_decoder_unit #(
  parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] new_body
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tuser    // [0] kind
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_nb_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_kind_q;

  logic       advance;
  logic       in_fire;
  logic       step_en;

  cbd_pkg::cbd_result_t res;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign step_en       = in_valid_q && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  assign out_valid_d = advance ? (step_en && res.valid) : out_valid_q;

  cbd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .data_byte_i (in_byte_q),
    .new_body_i  (in_nb_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata;
      in_nb_q   <= s_axis_tuser;
    end
    if (step_en) begin
      out_byte_q <= res.payload;
      out_kind_q <= res.kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

// ===== rtl/cbd_checker.sv =====
// ----------------------------------------------------------------------------
// cbd_checker
// Port-level checks of the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tuser ^ (^s_axis_tdata);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output item changed while stalled")
  `ASSERT_IMPL(a_end_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == cbd_pkg::KIND_END, m_axis_tdata == 8'h00, "end marker carries nonzero data")
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")
  `ASSERT_PROP(a_no_out_unknown, clk_i, rst_ni, !$isunknown(m_axis_tvalid), "output valid unknown")

endmodule

bind chunked_body_decoder_unit cbd_checker u_cbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the chunked body decoder: streams raw body bytes in, predicts the
// decoded payload bytes and end markers, and compares every output item with
// the oldest prediction under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SZW = cbd_pkg::SIZE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {ST_SIZE, ST_DATA, ST_SKIP, ST_DONE} parse_st_e;

  typedef struct packed {
    logic [7:0] data;
    logic       new_body;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       kind;
  } dec_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic       s_axis_tuser = 1'b0;    // [0] new_body
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] payload_byte
  logic       m_axis_tuser;           // [0] kind

  raw_item_t  raw_q[$];
  dec_out_t   decoded_q[$];

  // parser shadow state
  parse_st_e      prs_phase = ST_SIZE;
  logic [SZW-1:0] chunk_left = '0;
  logic           digits_done = 1'b0;
  logic           cr_seen = 1'b0;
  logic [1:0]     skip_left = 2'd0;

  // body builder state
  logic        body_start = 1'b0;
  int unsigned body_len = 0;
  int unsigned cut_len = 32'hFFFF_FFFF;

  int          bytes_taken = 0;
  int          err_cnt = 0;
  int          quiet_cycles = 0;
  logic        no_idle;
  dec_out_t    got_out;
  dec_out_t    want_out;
  raw_item_t   next_raw;

  assign no_idle = (bytes_taken >= 500) && (bytes_taken < 850);

  chunked_body_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------- prediction ----------------

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic void restart_line();
    prs_phase   = ST_SIZE;
    chunk_left  = '0;
    digits_done = 1'b0;
    cr_seen     = 1'b0;
    skip_left   = 2'd0;
  endfunction

  task automatic decode_step(input logic [7:0] b, input logic nb);
    int nib;
    if (nb) restart_line();
    case (prs_phase)
      ST_SIZE: begin
        if (cr_seen && b == cbd_pkg::CHAR_LF) begin
          cr_seen     = 1'b0;
          digits_done = 1'b0;
          if (chunk_left == '0) begin
            prs_phase = ST_DONE;
            decoded_q.push_back('{pbyte: 8'h00, kind: cbd_pkg::KIND_END});
          end else begin
            prs_phase = ST_DATA;
          end
        end else begin
          cr_seen = (b == cbd_pkg::CHAR_CR);
          if (!digits_done) begin
            nib = hex_nibble(b);
            if (nib < 0) digits_done = 1'b1;
            else chunk_left = {chunk_left[SZW-5:0], 4'(nib)};
          end
        end
      end
      ST_DATA: begin
        chunk_left = chunk_left - 1'b1;
        if (chunk_left == '0) begin
          prs_phase = ST_SKIP;
          skip_left = cbd_pkg::SKIP_BYTES;
        end
        decoded_q.push_back('{pbyte: b, kind: cbd_pkg::KIND_PAYLOAD});
      end
      ST_SKIP: begin
        if (skip_left != 2'd0) skip_left = skip_left - 1'b1;
        if (skip_left == 2'd0) restart_line();
      end
      default: ;
    endcase
  endtask

  // ---------------- stimulus builders ----------------

  task automatic push_byte(input logic [7:0] b);
    if (body_len < cut_len) begin
      raw_q.push_back('{data: b, new_body: body_start});
      body_len++;
    end
    body_start = 1'b0;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input int unsigned nib, input bit upper);
    if (nib < 10) return 8'(8'h30 + nib);
    return upper ? 8'(8'h41 + nib - 10) : 8'(8'h61 + nib - 10);
  endfunction

  // wrapped: a nonzero digit above 8 digits of the size, so only the size survives
  task automatic add_size_line(input int unsigned sz, input bit wrapped);
    int nd;
    nd = 1;
    while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
    if (wrapped) begin
      push_byte(hex_char($urandom_range(1, 15), 1'($urandom_range(0, 1))));
      nd = 8;
    end else if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) push_byte(8'h30);
    end
    for (int i = nd - 1; i >= 0; i--)
      push_byte(hex_char((sz >> (4 * i)) & 15, 1'($urandom_range(0, 1))));
    case ($urandom_range(0, 9))
      0: begin
        push_byte(8'h3B);   // extension, never interpreted
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(8'h67, 8'h7A)));
      end
      1: push_byte(cbd_pkg::CHAR_CR);  // CR CR LF
      2: begin
        push_byte(cbd_pkg::CHAR_CR);   // CR not followed by LF
        push_byte(8'h20);
      end
      default: ;
    endcase
    push_byte(cbd_pkg::CHAR_CR);
    push_byte(cbd_pkg::CHAR_LF);
  endtask

  task automatic add_body();
    int unsigned r, sz;
    body_start = 1'b1;
    body_len   = 0;
    cut_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 32'hFFFF_FFFF;
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 99);
      if (r < 70)      sz = $urandom_range(1, 8);
      else if (r < 90) sz = $urandom_range(9, 40);
      else if (r < 98) sz = $urandom_range(41, 300);
      else             sz = $urandom_range(1, 5);
      add_size_line(sz, r >= 98);
      repeat (sz) push_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 85) begin
        push_byte(cbd_pkg::CHAR_CR);
        push_byte(cbd_pkg::CHAR_LF);
      end else begin
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
      end
    end
    case ($urandom_range(0, 9))
      0, 1:    push_text("\r\n");
      2:       push_text("zz\r\n");
      default: add_size_line(0, 1'b0);
    endcase
    // trailer or junk after the end marker
    repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
    cut_len = 32'hFFFF_FFFF;
  endtask

  // ---------------- driver ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_step(s_axis_tdata, s_axis_tuser);
        bytes_taken <= bytes_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (raw_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 35)) begin
          next_raw = raw_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_raw.data;
          s_axis_tuser  <= next_raw.new_body;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  task automatic note_mismatch(input string what, input dec_out_t want, input dec_out_t got);
    if (err_cnt < 10)
      $display("[%0t] %s: expected byte=%02h kind=%0d, got byte=%02h kind=%0d",
               $time, what, want.pbyte, want.kind, got.pbyte, got.kind);
    err_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_out = '{pbyte: m_axis_tdata, kind: m_axis_tuser};
        if (decoded_q.size() == 0) begin
          note_mismatch("unexpected item", '0, got_out);
        end else begin
          want_out = decoded_q.pop_front();
          if (got_out.pbyte !== want_out.pbyte || got_out.kind !== want_out.kind)
            note_mismatch("mismatch", want_out, got_out);
        end
      end
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 35);
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress, %0d items still expected", decoded_q.size());
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    // empty size line, then a byte after the end marker
    body_start = 1'b1;
    push_text("\r\n");
    push_byte(8'hFF);
    // size line with no hex digit
    body_start = 1'b1;
    push_text("zz\r\n");
    // oversized size wraps to 2, line closed by CR CR LF
    body_start = 1'b1;
    push_text("100000002\r\r\n");
    push_byte(8'h00);
    push_byte(8'hFF);
    // bytes after a payload dropped whatever they hold
    push_byte(8'h5A);
    push_byte(8'hA5);
    push_text("0\r\n");

    while (raw_q.size() < 1420) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 20)) begin
          body_start = ($urandom_range(0, 7) == 0);
          push_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        add_body();
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (raw_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cbd_pkg.sv
rtl/cbd_parser.sv
rtl/chunked_body_decoder_unit.sv
rtl/cbd_checker.sv
verif/tb_top.sv
